### sv/sfcp_pkg.sv
// Shared types and constants for the serial frame checksum parser.
`default_nettype none

package sfcp_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned HEADER_BYTES = 3;
  localparam int unsigned BODY_MAX_DEF = 64;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;

  typedef enum logic [1:0] {
    STATUS_NONE = 2'd0,
    STATUS_GOOD = 2'd1,
    STATUS_BAD  = 2'd2,
    STATUS_LONG = 2'd3
  } status_e;

  typedef struct packed {
    logic              body_valid;
    logic [IDX_W-1:0]  body_index;
    logic [BYTE_W-1:0] body_byte;
    logic              frame_end;
    status_e           frame_status;
  } result_t;

endpackage

`default_nettype wire

### sv/serial_frame_checksum_parser.sv
// Top level of the serial frame checksum parser.
//
//   channel  direction  handshake                 data
//   cfg      in         cfg_valid_i / cfg_ready_o  cfg_start_marker_i
//   in       in         in_valid_i / in_stall_o    rx_byte_i
//   out      out        out_valid_o / out_stall_i  body_*_o, frame_end_o, frame_status_o
//
// One byte per cycle sustained while out_stall_i is low; each byte gives exactly one result.
// Each byte passes the input register, then the frame logic into the result register.
// The frame state (phase, count, length, checksum) updates as a byte enters the result stage.
// A stalled result holds the result register, then the input register, then in_stall_o rises.
// Reset returns to idle with start marker 0x02; cfg_ready_o is always high.
`default_nettype none

module serial_frame_checksum_parser #(
  parameter int unsigned BODY_MAX = sfcp_pkg::BODY_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfcp_pkg::BYTE_W-1:0]  cfg_start_marker_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sfcp_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         body_valid_o,
  output logic [sfcp_pkg::IDX_W-1:0]   body_index_o,
  output logic [sfcp_pkg::BYTE_W-1:0]  body_byte_o,
  output logic                         frame_end_o,
  output logic [1:0]                   frame_status_o
);

  logic                        down_ready;
  logic                        s1_valid;
  logic [sfcp_pkg::BYTE_W-1:0] s1_byte;
  logic                        step;
  sfcp_pkg::result_t           core_res;
  sfcp_pkg::result_t           out_res;

  assign cfg_ready_o = 1'b1;
  assign step        = s1_valid && down_ready;

  sfcp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .down_ready_i (down_ready),
    .s1_valid_o   (s1_valid),
    .s1_byte_o    (s1_byte)
  );

  sfcp_core #(
    .BODY_MAX (BODY_MAX)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_start_marker_i),
    .step_i     (step),
    .byte_i     (s1_byte),
    .result_o   (core_res)
  );

  sfcp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (core_res),
    .ready_o     (down_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign body_valid_o   = out_res.body_valid;
  assign body_index_o   = out_res.body_index;
  assign body_byte_o    = out_res.body_byte;
  assign frame_end_o    = out_res.frame_end;
  assign frame_status_o = out_res.frame_status;

endmodule

`default_nettype wire

### sv/sfcp_in_reg.sv
// Input register stage: captures received bytes and applies back pressure.
`default_nettype none

module sfcp_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [sfcp_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                      down_ready_i,
  output logic                      s1_valid_o,
  output logic [sfcp_pkg::BYTE_W-1:0] s1_byte_o
);

  logic                        valid_q;
  logic [sfcp_pkg::BYTE_W-1:0] byte_q;
  logic                        accept;
  logic                        advance;

  assign advance    = valid_q && down_ready_i;
  assign in_stall_o = valid_q && !down_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_byte_o  = byte_q;

endmodule

`default_nettype wire

### sv/sfcp_core.sv
// Frame state machine, running checksum and per-byte result logic.
`default_nettype none

module sfcp_core #(
  parameter int unsigned BODY_MAX = sfcp_pkg::BODY_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfcp_pkg::BYTE_W-1:0] cfg_data_i,
  input  logic                        step_i,
  input  logic [sfcp_pkg::BYTE_W-1:0] byte_i,
  output sfcp_pkg::result_t           result_o
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_e;

  localparam logic [8:0] BodyMaxW  = 9'(BODY_MAX);
  localparam logic [8:0] HeaderW   = 9'(sfcp_pkg::HEADER_BYTES);
  localparam logic [sfcp_pkg::CNT_W-1:0] BodyMaxC = sfcp_pkg::CNT_W'(BODY_MAX);
  localparam logic [sfcp_pkg::CNT_W-1:0] HeaderC  =
    sfcp_pkg::CNT_W'(sfcp_pkg::HEADER_BYTES);

  phase_e                        phase_q, phase_d;
  logic [sfcp_pkg::CNT_W-1:0]    count_q, count_d;
  logic [sfcp_pkg::BYTE_W-1:0]   len_q, len_d;
  logic [sfcp_pkg::BYTE_W-1:0]   sum_q, sum_d;
  logic [sfcp_pkg::BYTE_W-1:0]   marker_q;
  logic [sfcp_pkg::CNT_W-1:0]    count_inc;
  logic [sfcp_pkg::BYTE_W-1:0]   pay_len;
  logic [sfcp_pkg::BYTE_W-1:0]   expect_sum;
  sfcp_pkg::result_t             res;

  assign count_inc  = count_q + sfcp_pkg::CNT_W'(1);
  assign pay_len    = (byte_i == '0) ? sfcp_pkg::BYTE_W'(1) : byte_i;
  assign expect_sum = sfcp_pkg::BYTE_W'(0) - sum_q;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    len_d   = len_q;
    sum_d   = sum_q;
    res     = '0;
    unique case (phase_q)
      PH_IDLE: begin
        if (byte_i == marker_q) begin
          count_d = '0;
          sum_d   = '0;
          len_d   = '0;
          phase_d = PH_HEADER;
        end
      end
      PH_HEADER: begin
        res.body_valid = 1'b1;
        res.body_index = count_q[sfcp_pkg::IDX_W-1:0];
        res.body_byte  = byte_i;
        sum_d          = sum_q + byte_i;
        count_d        = count_inc;
        if (count_inc >= HeaderC) begin
          len_d = byte_i;
          if (HeaderW + {1'b0, pay_len} > BodyMaxW) begin
            phase_d          = PH_IDLE;
            count_d          = '0;
            res.frame_end    = 1'b1;
            res.frame_status = sfcp_pkg::STATUS_LONG;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res.body_valid = 1'b1;
        res.body_index = count_q[sfcp_pkg::IDX_W-1:0];
        res.body_byte  = byte_i;
        sum_d          = sum_q + byte_i;
        count_d        = count_inc;
        if ({2'b00, count_inc} >= HeaderW + {1'b0, len_q} || count_inc >= BodyMaxC) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res.frame_end    = 1'b1;
        res.frame_status = (expect_sum == byte_i) ? sfcp_pkg::STATUS_GOOD
                                                  : sfcp_pkg::STATUS_BAD;
        phase_d          = PH_IDLE;
        count_d          = '0;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      count_q  <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      marker_q <= sfcp_pkg::START_MARKER_RST;
    end else begin
      if (cfg_we_i) begin
        marker_q <= cfg_data_i;
      end
      if (step_i) begin
        phase_q <= phase_d;
        count_q <= count_d;
        len_q   <= len_d;
        sum_q   <= sum_d;
      end
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

### sv/sfcp_out_reg.sv
// Result register stage: holds one result until the consumer takes it.
`default_nettype none

module sfcp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  sfcp_pkg::result_t result_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfcp_pkg::result_t result_o
);

  logic              valid_q;
  sfcp_pkg::result_t result_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### sv/sfcp_checker.sv
// Port-level assertions for the serial frame checksum parser, with bind.
`default_nettype none

module sfcp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        body_valid_o,
  input logic [sfcp_pkg::IDX_W-1:0]  body_index_o,
  input logic [sfcp_pkg::BYTE_W-1:0] body_byte_o,
  input logic                        frame_end_o,
  input logic [1:0]                  frame_status_o
);

  localparam logic [sfcp_pkg::IDX_W-1:0] LastHdrIdx =
    sfcp_pkg::IDX_W'(sfcp_pkg::HEADER_BYTES - 1);

  a_status_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> frame_status_o == sfcp_pkg::STATUS_NONE)
    else $error("status without frame end");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !body_valid_o |-> body_index_o == '0 && body_byte_o == '0)
    else $error("body fields set without body byte");

  a_checksum_no_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == sfcp_pkg::STATUS_GOOD ||
                    frame_status_o == sfcp_pkg::STATUS_BAD)
    |-> frame_end_o && !body_valid_o)
    else $error("checksum result carries a body byte");

  a_long_on_last_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o == sfcp_pkg::STATUS_LONG
    |-> frame_end_o && body_valid_o && body_index_o == LastHdrIdx)
    else $error("length error not on last header byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(body_byte_o) &&
    $stable(body_index_o) && $stable(frame_status_o))
    else $error("stalled result changed");

endmodule

bind serial_frame_checksum_parser sfcp_checker u_sfcp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .body_valid_o   (body_valid_o),
  .body_index_o   (body_index_o),
  .body_byte_o    (body_byte_o),
  .frame_end_o    (frame_end_o),
  .frame_status_o (frame_status_o)
);

`default_nettype wire
